// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;          // one signed product
   localparam int WIDE_BITS = PROD_BITS + 1;          // sum of two products
   localparam int SHR_BITS  = WIDE_BITS - FRAC_BITS;  // product sum after scaling
   localparam int QUO_BITS  = WORD_BITS;              // quotient bits resolved
   localparam int DIV_STAGES = QUO_BITS;

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_ADD = 3'd0;
   localparam cmd_type CMD_SUB = 3'd1;
   localparam cmd_type CMD_MUL = 3'd2;
   localparam cmd_type CMD_DIV = 3'd3;
   localparam cmd_type CMD_EQ  = 3'd4;
   localparam cmd_type CMD_NE  = 3'd5;

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] val;
   } satw_type;

   // one slot of the divider pipeline, carries every result kind along
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic [WIDE_BITS-1:0] den;
      logic [WIDE_BITS-1:0] rem_re;
      logic [QUO_BITS-1:0]  nq_re;
      logic                 neg_re;
      logic                 ovf_re;
      logic [WIDE_BITS-1:0] rem_im;
      logic [QUO_BITS-1:0]  nq_im;
      logic                 neg_im;
      logic                 ovf_im;
      logic [WORD_BITS-1:0] res_re;
      logic [WORD_BITS-1:0] res_im;
      logic                 cmp;
      logic                 dbz;
      logic                 sat;
   } slot_type;

   function automatic satw_type sat_word(input logic signed [SHR_BITS-1:0] v);
      satw_type r;
      logic signed [SHR_BITS-1:0] hi;
      logic signed [SHR_BITS-1:0] lo;
      hi = SHR_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
      lo = -hi - SHR_BITS'(1);
      if (v > hi) begin
         r.sat = 1'b1;
         r.val = hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         r.sat = 1'b1;
         r.val = lo[WORD_BITS-1:0];
      end else begin
         r.sat = 1'b0;
         r.val = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   // quotient magnitude and sign to a clamped signed word
   function automatic satw_type sat_quo(input logic [QUO_BITS-1:0] q, input logic neg,
                                        input logic ovf);
      satw_type r;
      logic [QUO_BITS-1:0] lim;
      lim = {1'b0, {(QUO_BITS-1){1'b1}}} + QUO_BITS'(neg);
      if (ovf || q > lim) begin
         r.sat = 1'b1;
         r.val = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
         r.sat = 1'b0;
         r.val = neg ? (~q + QUO_BITS'(1)) : q;
      end
      return r;
   endfunction

endpackage

// ----- src/cau_div_stage.sv -----
// ----------------------------------------------------------------------------
// cau_div_stage
// One registered restoring-division step for both result parts.
// ----------------------------------------------------------------------------
module cau_div_stage import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  slot_type slot_in,
   output slot_type slot_out
);

   slot_type slot_ff;
   slot_type slot_in_n;
   logic [WIDE_BITS:0] tr_re;
   logic [WIDE_BITS:0] tr_im;
   logic               ge_re;
   logic               ge_im;
   logic [WIDE_BITS:0] sub_re;
   logic [WIDE_BITS:0] sub_im;

   always_comb begin
      slot_in_n = slot_in;
      tr_re  = {slot_in.rem_re, slot_in.nq_re[QUO_BITS-1]};
      tr_im  = {slot_in.rem_im, slot_in.nq_im[QUO_BITS-1]};
      ge_re  = tr_re >= {1'b0, slot_in.den};
      ge_im  = tr_im >= {1'b0, slot_in.den};
      sub_re = ge_re ? tr_re - {1'b0, slot_in.den} : tr_re;
      sub_im = ge_im ? tr_im - {1'b0, slot_in.den} : tr_im;
      slot_in_n.valid  = slot_in.valid && !reset;
      slot_in_n.rem_re = sub_re[WIDE_BITS-1:0];
      slot_in_n.rem_im = sub_im[WIDE_BITS-1:0];
      slot_in_n.nq_re  = {slot_in.nq_re[QUO_BITS-2:0], ge_re};
      slot_in_n.nq_im  = {slot_in.nq_im[QUO_BITS-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in_n;
   end

   assign slot_out = slot_ff;

endmodule

// ----- src/complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide and compare on Q16.16 parts.
// Latency is the same for every command; one transaction enters each cycle.
// The pipeline holds the 32-step restoring divider, one quotient bit a stage.
// busy never rises; the result strobe cannot be held off.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_cmd,
   input  logic signed [WORD_BITS-1:0] req_a_re,
   input  logic signed [WORD_BITS-1:0] req_a_im,
   input  logic signed [WORD_BITS-1:0] req_b_re,
   input  logic signed [WORD_BITS-1:0] req_b_im,
   output logic                        rsp_strobe,
   output logic signed [WORD_BITS-1:0] rsp_res_re,
   output logic signed [WORD_BITS-1:0] rsp_res_im,
   output logic                        rsp_compare_true,
   output logic                        rsp_div_by_zero,
   output logic                        rsp_saturated
);

   // stage 1: products, sums, differences, equality
   logic                        v1_ff;
   cmd_type                     cmd1_ff;
   logic signed [PROD_BITS-1:0] ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;
   logic signed [WORD_BITS:0]   sre_ff, sim_ff, dre_ff, dim_ff;
   logic                        eq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      cmd1_ff <= req_cmd;
      ac_ff   <= req_a_re * req_b_re;
      bd_ff   <= req_a_im * req_b_im;
      ad_ff   <= req_a_re * req_b_im;
      bc_ff   <= req_a_im * req_b_re;
      cc_ff   <= req_b_re * req_b_re;
      dd_ff   <= req_b_im * req_b_im;
      sre_ff  <= {req_a_re[WORD_BITS-1], req_a_re} + {req_b_re[WORD_BITS-1], req_b_re};
      sim_ff  <= {req_a_im[WORD_BITS-1], req_a_im} + {req_b_im[WORD_BITS-1], req_b_im};
      dre_ff  <= {req_a_re[WORD_BITS-1], req_a_re} - {req_b_re[WORD_BITS-1], req_b_re};
      dim_ff  <= {req_a_im[WORD_BITS-1], req_a_im} - {req_b_im[WORD_BITS-1], req_b_im};
      eq_ff   <= (req_a_re == req_b_re) && (req_a_im == req_b_im);
   end

   // stage 2: product sums, add/sub results, compare result
   logic                        v2_ff;
   cmd_type                     cmd2_ff;
   logic signed [WIDE_BITS-1:0] t1_ff, t2_ff, nr_ff, ni_ff;
   logic [WIDE_BITS-1:0]        den_ff;
   logic [WORD_BITS-1:0]        ar_re_ff, ar_im_ff;
   logic                        ar_sat_ff, cmp2_ff;
   satw_type                    w_re_in, w_im_in;

   always_comb begin
      w_re_in = '0;
      w_im_in = '0;
      case (cmd1_ff)
         CMD_ADD: begin
            w_re_in = sat_word(SHR_BITS'(sre_ff));
            w_im_in = sat_word(SHR_BITS'(sim_ff));
         end
         CMD_SUB: begin
            w_re_in = sat_word(SHR_BITS'(dre_ff));
            w_im_in = sat_word(SHR_BITS'(dim_ff));
         end
         default: begin
            w_re_in = '0;
            w_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      cmd2_ff   <= cmd1_ff;
      t1_ff     <= WIDE_BITS'(ac_ff) - WIDE_BITS'(bd_ff);
      t2_ff     <= WIDE_BITS'(ad_ff) + WIDE_BITS'(bc_ff);
      nr_ff     <= WIDE_BITS'(ac_ff) + WIDE_BITS'(bd_ff);
      ni_ff     <= WIDE_BITS'(bc_ff) - WIDE_BITS'(ad_ff);
      den_ff    <= WIDE_BITS'(cc_ff) + WIDE_BITS'(dd_ff);
      ar_re_ff  <= w_re_in.val;
      ar_im_ff  <= w_im_in.val;
      ar_sat_ff <= w_re_in.sat | w_im_in.sat;
      cmp2_ff   <= ((cmd1_ff == CMD_EQ) && eq_ff) || ((cmd1_ff == CMD_NE) && !eq_ff);
   end

   // stage 3: scale products, set up the divider
   slot_type                    slot_in;
   logic signed [WIDE_BITS-1:0] b1, b2;
   logic [WIDE_BITS-1:0]        mr, mi;
   logic                        dz;
   satw_type                    m_re, m_im;

   always_comb begin
      b1 = t1_ff + (t1_ff[WIDE_BITS-1] ? WIDE_BITS'({FRAC_BITS{1'b1}}) : '0);
      b2 = t2_ff + (t2_ff[WIDE_BITS-1] ? WIDE_BITS'({FRAC_BITS{1'b1}}) : '0);
      m_re = sat_word(SHR_BITS'(b1 >>> FRAC_BITS));
      m_im = sat_word(SHR_BITS'(b2 >>> FRAC_BITS));
      mr = nr_ff[WIDE_BITS-1] ? -nr_ff : nr_ff;
      mi = ni_ff[WIDE_BITS-1] ? -ni_ff : ni_ff;
      dz = (den_ff == '0);
      slot_in = '0;
      slot_in.valid  = v2_ff && !reset;
      slot_in.is_div = (cmd2_ff == CMD_DIV) && !dz;
      slot_in.den    = den_ff;
      slot_in.rem_re = mr >> FRAC_BITS;
      slot_in.nq_re  = {mr[FRAC_BITS-1:0], {(QUO_BITS-FRAC_BITS){1'b0}}};
      slot_in.neg_re = nr_ff[WIDE_BITS-1];
      slot_in.ovf_re = {{FRAC_BITS{1'b0}}, mr} >= {den_ff, {FRAC_BITS{1'b0}}};
      slot_in.rem_im = mi >> FRAC_BITS;
      slot_in.nq_im  = {mi[FRAC_BITS-1:0], {(QUO_BITS-FRAC_BITS){1'b0}}};
      slot_in.neg_im = ni_ff[WIDE_BITS-1];
      slot_in.ovf_im = {{FRAC_BITS{1'b0}}, mi} >= {den_ff, {FRAC_BITS{1'b0}}};
      slot_in.cmp    = cmp2_ff;
      slot_in.dbz    = (cmd2_ff == CMD_DIV) && dz;
      case (cmd2_ff)
         CMD_ADD, CMD_SUB: begin
            slot_in.res_re = ar_re_ff;
            slot_in.res_im = ar_im_ff;
            slot_in.sat    = ar_sat_ff;
         end
         CMD_MUL: begin
            slot_in.res_re = m_re.val;
            slot_in.res_im = m_im.val;
            slot_in.sat    = m_re.sat | m_im.sat;
         end
         default: begin
            slot_in.res_re = '0;
            slot_in.res_im = '0;
            slot_in.sat    = 1'b0;
         end
      endcase
   end

   slot_type slot3_ff;

   always_ff @(posedge clock) begin
      slot3_ff <= slot_in;
   end

   // divider chain
   slot_type chain [DIV_STAGES+1];

   assign chain[0] = slot3_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      cau_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .slot_in  (chain[g]),
         .slot_out (chain[g+1])
      );
   end

   // output register
   slot_type             last;
   satw_type             q_re, q_im;
   logic                 strobe_ff;
   logic [WORD_BITS-1:0] re_ff, im_ff;
   logic                 cmp_ff, dbz_ff, sat_ff;

   always_comb begin
      last = chain[DIV_STAGES];
      q_re = sat_quo(last.nq_re, last.neg_re, last.ovf_re);
      q_im = sat_quo(last.nq_im, last.neg_im, last.ovf_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= last.valid;
      end
      re_ff  <= last.is_div ? q_re.val : last.res_re;
      im_ff  <= last.is_div ? q_im.val : last.res_im;
      sat_ff <= last.is_div ? (q_re.sat | q_im.sat) : last.sat;
      cmp_ff <= last.cmp;
      dbz_ff <= last.dbz;
   end

   assign busy             = 1'b0;
   assign rsp_strobe       = strobe_ff;
   assign rsp_res_re       = re_ff;
   assign rsp_res_im       = im_ff;
   assign rsp_compare_true = cmp_ff;
   assign rsp_div_by_zero  = dbz_ff;
   assign rsp_saturated    = sat_ff;

endmodule
